>>> hw/rtl/lpht_pkg.sv
// lpht_pkg: shared types and constants for the linear-probe hash table.
// Used by lpht_seq, the top level and the checker; no dependencies.
package lpht_pkg;

  localparam int unsigned IDX_W      = 6;
  localparam int unsigned CAPACITY   = 1 << IDX_W;
  localparam int unsigned HASH_W     = 64;
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned CNT_W      = IDX_W + 1;
  localparam int unsigned LIMIT_W    = 7;

  localparam logic [LIMIT_W-1:0] FILL_LIMIT_RST = LIMIT_W'(48);

  typedef enum logic [1:0] {
    OP_SET = 2'd0,
    OP_GET = 2'd1,
    OP_DEL = 2'd2
  } req_op_t;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_TOMB  = 2'd1,
    ST_USED  = 2'd2
  } slot_st_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHK,
    S_ACT
  } seq_state_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [HASH_W-1:0] key_hash;
    logic [31:0]       write_value;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic        status;
  } rsp_t;

  typedef struct packed {
    slot_st_t              st;
    logic [HASH_W-1:0]     hash;
    logic [VALUE_BITS-1:0] value;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

  // table RAM command from the sequencer
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    slot_t            wr_data;
  } ram_cmd_t;

endpackage

>>> hw/rtl/lpht_ram.sv
// lpht_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module lpht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/lpht_seq.sv
// lpht_seq: probe sequencer; walks slots one per cycle, then applies the request.
// Depends on lpht_pkg; drives the table RAM through a lpht_pkg::ram_cmd_t.
module lpht_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lpht_pkg::req_t                in_req,
  input  logic [lpht_pkg::LIMIT_W-1:0]  fill_limit,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output lpht_pkg::rsp_t                rsp,
  output lpht_pkg::ram_cmd_t            ram_cmd,
  input  lpht_pkg::slot_t               ram_rd_data
);

  lpht_pkg::seq_state_t             state_r, state_nxt;
  lpht_pkg::req_t                   req_r, req_nxt;
  logic [lpht_pkg::IDX_W-1:0]       idx_r, idx_nxt;
  logic [lpht_pkg::IDX_W-1:0]       cnt_r, cnt_nxt;
  logic                             tomb_found_r, tomb_found_nxt;
  logic [lpht_pkg::IDX_W-1:0]       tomb_idx_r, tomb_idx_nxt;
  logic                             sel_ok_r, sel_ok_nxt;
  lpht_pkg::slot_st_t               sel_st_r, sel_st_nxt;
  logic [lpht_pkg::IDX_W-1:0]       sel_idx_r, sel_idx_nxt;
  logic [lpht_pkg::VALUE_BITS-1:0]  sel_value_r, sel_value_nxt;
  logic [lpht_pkg::CAPACITY-1:0]    valid_r, valid_nxt;
  logic [lpht_pkg::CNT_W-1:0]       fill_r, fill_nxt;

  lpht_pkg::slot_st_t               cur_st;
  logic                             match;
  logic                             over_limit;

  // a slot never written reads as empty
  assign cur_st = valid_r[idx_r] ? ram_rd_data.st : lpht_pkg::ST_EMPTY;
  assign match  = (cur_st == lpht_pkg::ST_USED) && (ram_rd_data.hash == req_r.key_hash);
  assign over_limit = ({1'b0, fill_r} + (lpht_pkg::CNT_W + 1)'(1))
                      > (lpht_pkg::CNT_W + 1)'(fill_limit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lpht_pkg::S_IDLE;
      valid_r <= '0;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    idx_r        <= idx_nxt;
    cnt_r        <= cnt_nxt;
    tomb_found_r <= tomb_found_nxt;
    tomb_idx_r   <= tomb_idx_nxt;
    sel_ok_r     <= sel_ok_nxt;
    sel_st_r     <= sel_st_nxt;
    sel_idx_r    <= sel_idx_nxt;
    sel_value_r  <= sel_value_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    tomb_found_nxt = tomb_found_r;
    tomb_idx_nxt   = tomb_idx_r;
    sel_ok_nxt     = sel_ok_r;
    sel_st_nxt     = sel_st_r;
    sel_idx_nxt    = sel_idx_r;
    sel_value_nxt  = sel_value_r;
    valid_nxt      = valid_r;
    fill_nxt       = fill_r;
    in_ready       = 1'b0;
    rsp_valid      = 1'b0;
    rsp            = '0;
    ram_cmd        = '0;

    case (state_r)
      lpht_pkg::S_IDLE: begin
        in_ready        = 1'b1;
        ram_cmd.rd_en   = in_valid;
        ram_cmd.rd_addr = in_req.key_hash[lpht_pkg::IDX_W-1:0];
        if (in_valid) begin
          req_nxt        = in_req;
          idx_nxt        = in_req.key_hash[lpht_pkg::IDX_W-1:0];
          cnt_nxt        = '0;
          tomb_found_nxt = 1'b0;
          sel_ok_nxt     = 1'b0;
          sel_st_nxt     = lpht_pkg::ST_EMPTY;
          if (in_req.req_type == lpht_pkg::OP_SET || in_req.req_type == lpht_pkg::OP_GET ||
              in_req.req_type == lpht_pkg::OP_DEL) begin
            state_nxt = lpht_pkg::S_CHK;
          end else begin
            state_nxt = lpht_pkg::S_ACT;
          end
        end
      end

      lpht_pkg::S_CHK: begin
        // prefetch the next slot; discarded if the probe stops here
        ram_cmd.rd_en   = 1'b1;
        ram_cmd.rd_addr = idx_r + lpht_pkg::IDX_W'(1);
        if (match) begin
          sel_ok_nxt    = 1'b1;
          sel_st_nxt    = lpht_pkg::ST_USED;
          sel_idx_nxt   = idx_r;
          sel_value_nxt = ram_rd_data.value;
          state_nxt     = lpht_pkg::S_ACT;
        end else if (cur_st == lpht_pkg::ST_EMPTY) begin
          sel_ok_nxt  = 1'b1;
          sel_st_nxt  = tomb_found_r ? lpht_pkg::ST_TOMB : lpht_pkg::ST_EMPTY;
          sel_idx_nxt = tomb_found_r ? tomb_idx_r : idx_r;
          state_nxt   = lpht_pkg::S_ACT;
        end else if (cnt_r == '1) begin
          // whole table visited: fall back to first tombstone, if any
          sel_ok_nxt  = tomb_found_r || (cur_st == lpht_pkg::ST_TOMB);
          sel_st_nxt  = lpht_pkg::ST_TOMB;
          sel_idx_nxt = tomb_found_r ? tomb_idx_r : idx_r;
          state_nxt   = lpht_pkg::S_ACT;
        end else begin
          if (cur_st == lpht_pkg::ST_TOMB && !tomb_found_r) begin
            tomb_found_nxt = 1'b1;
            tomb_idx_nxt   = idx_r;
          end
          idx_nxt = idx_r + lpht_pkg::IDX_W'(1);
          cnt_nxt = cnt_r + lpht_pkg::IDX_W'(1);
        end
      end

      lpht_pkg::S_ACT: begin
        rsp_valid       = 1'b1;
        ram_cmd.wr_addr = sel_idx_r;
        ram_cmd.wr_data.st    = lpht_pkg::ST_USED;
        ram_cmd.wr_data.hash  = req_r.key_hash;
        ram_cmd.wr_data.value = req_r.write_value[lpht_pkg::VALUE_BITS-1:0];
        case (req_r.req_type)
          lpht_pkg::OP_SET: begin
            if (!sel_ok_r) begin
              rsp.status = 1'b1;
            end else if (sel_st_r == lpht_pkg::ST_USED) begin
              ram_cmd.wr_en = 1'b1;
            end else if (sel_st_r == lpht_pkg::ST_TOMB) begin
              ram_cmd.wr_en = 1'b1;
              rsp.hit       = 1'b1;
            end else if (over_limit) begin
              rsp.status = 1'b1;
            end else begin
              ram_cmd.wr_en = 1'b1;
              rsp.hit       = 1'b1;
            end
          end
          lpht_pkg::OP_GET: begin
            if (sel_ok_r && sel_st_r == lpht_pkg::ST_USED) begin
              rsp.hit        = 1'b1;
              rsp.read_value = 32'(sel_value_r);
            end
          end
          lpht_pkg::OP_DEL: begin
            if (sel_ok_r && sel_st_r == lpht_pkg::ST_USED) begin
              rsp.hit               = 1'b1;
              ram_cmd.wr_en         = 1'b1;
              ram_cmd.wr_data.st    = lpht_pkg::ST_TOMB;
              ram_cmd.wr_data.value = sel_value_r;
            end
          end
          default: begin
          end
        endcase
        if (!rsp_ready) begin
          ram_cmd.wr_en = 1'b0;
        end else begin
          state_nxt = lpht_pkg::S_IDLE;
          if (ram_cmd.wr_en) begin
            valid_nxt[sel_idx_r] = 1'b1;
          end
          if (ram_cmd.wr_en && sel_st_r == lpht_pkg::ST_EMPTY) begin
            fill_nxt = fill_r + lpht_pkg::CNT_W'(1);
          end
        end
      end

      default: begin
        state_nxt = lpht_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/linear_probe_hash_table_unit.sv
// linear_probe_hash_table_unit: 64-slot open-addressing hash table, top level.
// Depends on lpht_pkg, lpht_seq and lpht_ram.
//
//   channel | ports                          | moves
//   --------+--------------------------------+-------------------------------------
//   in      | in_valid, in_ready, in_req     | request: set / get / delete by hash
//   out     | out_valid, out_ready, out_rsp  | one response per request
//   cfg     | cfg_wr_en, cfg_wr_data         | fill_limit write, no wait
//
// The sequencer probes 1..64 slots per request, then hands the response to the output
// register; unknown request types skip the probe.
// The single table RAM read port delivers one slot per cycle.
// One request is in flight at a time; in_ready is high only while the sequencer is idle.
// A response waits in the output register while the next request is taken.
// Reset clears the 64 slot valid bits and the fill count at once; no clearing pass.
module linear_probe_hash_table_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lpht_pkg::req_t                in_req,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lpht_pkg::rsp_t                out_rsp,
  input  logic                          cfg_wr_en,
  input  logic [lpht_pkg::LIMIT_W-1:0]  cfg_wr_data
);

  logic [lpht_pkg::LIMIT_W-1:0] fill_limit_r;
  logic                         out_valid_r;
  lpht_pkg::rsp_t               out_rsp_r;
  logic                         rsp_valid;
  logic                         rsp_ready;
  lpht_pkg::rsp_t               rsp;
  lpht_pkg::ram_cmd_t           ram_cmd;
  logic [lpht_pkg::SLOT_W-1:0]  ram_rd_bits;

  assign rsp_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_limit_r <= lpht_pkg::FILL_LIMIT_RST;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        fill_limit_r <= cfg_wr_data;
      end
      if (rsp_ready) begin
        out_valid_r <= rsp_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_ready && rsp_valid) begin
      out_rsp_r <= rsp;
    end
  end

  lpht_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req      (in_req),
    .fill_limit  (fill_limit_r),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .ram_cmd     (ram_cmd),
    .ram_rd_data (lpht_pkg::slot_t'(ram_rd_bits))
  );

  lpht_ram #(
    .WIDTH (lpht_pkg::SLOT_W),
    .DEPTH (lpht_pkg::CAPACITY)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_cmd.wr_en),
    .wr_addr (ram_cmd.wr_addr),
    .wr_data (ram_cmd.wr_data),
    .rd_en   (ram_cmd.rd_en),
    .rd_addr (ram_cmd.rd_addr),
    .rd_data (ram_rd_bits)
  );

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

>>> hw/rtl/lpht_chk.sv
// lpht_chk: port-level checker for linear_probe_hash_table_unit, bound to the top.
// Depends on lpht_pkg.
module lpht_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input lpht_pkg::rsp_t                out_rsp
);

  // one request in flight: in_ready is low in the cycle after a request is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("lpht: in_ready high right after a request was taken");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_rsp)))
    else $error("lpht: stalled response changed or dropped");

  a_refused_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.status) |-> (!out_rsp.hit && out_rsp.read_value == 32'd0))
    else $error("lpht: refused set reports hit or data");

  a_value_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.read_value != 32'd0) |-> out_rsp.hit)
    else $error("lpht: nonzero read_value without hit");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("lpht: response valid after reset");

endmodule

bind linear_probe_hash_table_unit lpht_chk u_lpht_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_rsp     (out_rsp)
);
